// ===== src/kei_pkg.sv =====
// Shared constants, types and tables for the keyframe eased interpolator.
`timescale 1ns / 1ps
`default_nettype none
package kei_pkg;

    localparam int MAX_KEYS   = 16;
    localparam int KEY_IDX_W  = $clog2(MAX_KEYS);
    localparam int DAY_LENGTH = 23040;

    localparam int TIME_W     = 15;
    localparam int VALUE_W    = 32;
    localparam int WEIGHT_W   = 17;
    localparam int COUNT_W    = 5;
    localparam int POWER_W    = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam int KEY_W      = VALUE_W + TIME_W;

    // Q0.16 fraction width and the exp2 table length
    localparam int FRAC_W     = 16;
    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(65536);

    // serial multiplier: digit bits per cycle, operand and accumulator widths
    localparam int MUL_DIGIT  = 4;
    localparam int MP_W       = 32;
    localparam int ACC_W      = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_COUNT  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_EASE_POWER = 1'b1;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_EVAL  = 1'b1;

    typedef logic [FRAC_W-1:0][29:0] exp_tbl_t;

    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bit_v;
        logic [63:0] rem;
        res   = '0;
        bit_v = 64'd1 << 62;
        rem   = v;
        for (int k = 0; k < 32; k++)
        begin
            if (rem >= res + bit_v)
            begin
                rem = rem - (res + bit_v);
                res = (res >> 1) + bit_v;
            end
            else
            begin
                res = res >> 1;
            end
            bit_v = bit_v >> 2;
        end
        return res;
    endfunction

    // c[i] = 2^(-2^-(i+1)) in Q0.30, built by repeated square roots
    function automatic exp_tbl_t exp_table();
        exp_tbl_t    tbl;
        logic [63:0] c;
        c = isqrt64(64'd1 << 59);
        for (int i = 0; i < FRAC_W; i++)
        begin
            tbl[i] = c[29:0];
            c      = isqrt64(c << 30);
        end
        return tbl;
    endfunction

    localparam exp_tbl_t EXP_C = exp_table();

endpackage
`default_nettype wire

// ===== src/kei_ram.sv =====
// Generic single write port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module kei_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
`default_nettype wire

// ===== src/keyframe_eased_interpolator.sv =====
// Top level: keyframe table, key scan, span division, eased weight and blend.
//
// A write beat stores one key. An evaluate beat scans the keys (stopping at
// the first key at or after the query), reads the two neighbors, divides the
// span bit-serially, then forms t^p and (1-t)^p through a log2 by 16
// squarings and an exp2 by up to 16 table products, and blends. Every product
// runs through one shared digit-serial multiplier, 4 bits of multiplier per
// cycle, which sets the pace. How long an evaluate takes depends on how far
// the scan runs and on the bits of the exponent products. When t is 0 or 1.0,
// or the power is zero, both powers resolve at once. One item is in work at a
// time; the finished result waits in an output register.
`timescale 1ns / 1ps
`default_nettype none
module keyframe_eased_interpolator
    import kei_pkg::*;
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,

    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic                        operation,
    input  wire logic        [KEY_IDX_W-1:0] key_index,
    input  wire logic        [TIME_W-1:0]    key_time,
    input  wire logic signed [VALUE_W-1:0]   key_value,
    input  wire logic        [TIME_W-1:0]    query_time,

    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic signed      [VALUE_W-1:0]   value,
    output logic             [KEY_IDX_W-1:0] prev_index,
    output logic             [KEY_IDX_W-1:0] next_index,
    output logic             [WEIGHT_W-1:0]  weight,

    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic        [CFG_IDX_W-1:0] cfg_index,
    input  wire logic        [CFG_DATA_W-1:0] cfg_data
);

    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_SCAN_RD  = 5'd1;
    localparam logic [4:0] S_SCAN_CK  = 5'd2;
    localparam logic [4:0] S_NEXT_RD  = 5'd3;
    localparam logic [4:0] S_NEXT_LD  = 5'd4;
    localparam logic [4:0] S_PREV_RD  = 5'd5;
    localparam logic [4:0] S_PREV_LD  = 5'd6;
    localparam logic [4:0] S_SPAN     = 5'd7;
    localparam logic [4:0] S_DIV      = 5'd8;
    localparam logic [4:0] S_POW_INIT = 5'd9;
    localparam logic [4:0] S_LOG_STEP = 5'd10;
    localparam logic [4:0] S_LOG_Q    = 5'd11;
    localparam logic [4:0] S_EXP      = 5'd12;
    localparam logic [4:0] S_EXP_STEP = 5'd13;
    localparam logic [4:0] S_POW_SH   = 5'd14;
    localparam logic [4:0] S_EASE_MUL = 5'd15;
    localparam logic [4:0] S_EASE_FIN = 5'd16;
    localparam logic [4:0] S_VAL_FIN  = 5'd17;
    localparam logic [4:0] S_MUL      = 5'd18;

    localparam logic signed [17:0] DAY18 = 18'(DAY_LENGTH);

    logic [4:0]             state_reg, state_next;
    logic [4:0]             ret_reg, ret_next;
    logic [COUNT_W-1:0]     key_count_reg;
    logic [POWER_W-1:0]     ease_power_reg;
    logic [TIME_W-1:0]      query_reg, query_next;
    logic [KEY_IDX_W-1:0]   idx_reg, idx_next;
    logic [KEY_IDX_W-1:0]   next_reg, next_next;
    logic [KEY_IDX_W-1:0]   prev_reg, prev_next;
    logic [TIME_W-1:0]      tn_reg, tn_next, tp_reg, tp_next;
    logic [VALUE_W-1:0]     vn_reg, vn_next, vp_reg, vp_next;
    logic [16:0]            den_reg, den_next;
    logic [17:0]            rem_reg, rem_next;
    logic [WEIGHT_W-1:0]    t_reg, t_next;
    logic [3:0]             cnt_reg, cnt_next;
    logic [WEIGHT_W-1:0]    pow_x_reg, pow_x_next;
    logic                   pow_b_reg, pow_b_next;
    logic [4:0]             log_int_reg, log_int_next;
    logic [FRAC_W-1:0]      frac_reg, frac_next;
    logic [7:0]             ipart_reg, ipart_next;
    logic [30:0]            r_reg, r_next;
    logic [WEIGHT_W-1:0]    a_reg, a_next, b_reg, b_next;
    logic                   neg_reg, neg_next;
    logic [WEIGHT_W-1:0]    w_reg, w_next;
    logic [ACC_W-1:0]       mc_reg, mc_next, acc_reg, acc_next;
    logic [MP_W-1:0]        mp_reg, mp_next;

    logic                   out_valid_reg, out_valid_next;
    logic [VALUE_W-1:0]     value_reg, value_next;
    logic [KEY_IDX_W-1:0]   prev_out_reg, prev_out_next;
    logic [KEY_IDX_W-1:0]   next_out_reg, next_out_next;
    logic [WEIGHT_W-1:0]    weight_reg, weight_next;

    logic                   in_accept;
    logic                   ram_we;
    logic [KEY_IDX_W-1:0]   ram_raddr;
    logic [KEY_W-1:0]       ram_rdata;
    logic [TIME_W-1:0]      rd_time;
    logic [VALUE_W-1:0]     rd_value;
    logic [KEY_IDX_W-1:0]   key_last;

    // combinational helpers of the sequencer
    logic                   mul_go;
    logic [ACC_W-1:0]       mul_mc;
    logic [MP_W-1:0]        mul_mp;
    logic [4:0]             mul_ret;
    logic                   pow_fin;
    logic [WEIGHT_W-1:0]    pow_res;
    logic [ACC_W-1:0]       part;
    logic signed [17:0]     den_s, num_s;
    logic [17:0]            rem2;
    logic [3:0]             msb;
    logic [4:0]             sh5;
    logic [16:0]            z0;
    logic [17:0]            sq;
    logic [16:0]            zn;
    logic [FRAC_W-1:0]      frac_sh;
    logic [20:0]            neg_log;
    logic [8:0]             sh9;
    logic [17:0]            diff18;
    logic [16:0]            dsh;
    logic signed [18:0]     e19;
    logic [32:0]            dv, dv_mag;
    logic [32:0]            vsh;
    logic [33:0]            vp34, v34;

    assign in_accept = in_valid && !in_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;

    assign out_valid  = out_valid_reg;
    assign value      = $signed(value_reg);
    assign prev_index = prev_out_reg;
    assign next_index = next_out_reg;
    assign weight     = weight_reg;

    assign ram_we = in_accept && (operation == OP_WRITE)
                    && ({1'b0, key_index} < (KEY_IDX_W+1)'(MAX_KEYS));

    kei_ram #(
        .WIDTH (KEY_W),
        .DEPTH (MAX_KEYS)
    ) u_key_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (key_index),
        .wr_data ({key_value, key_time}),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    assign rd_time  = ram_rdata[TIME_W-1:0];
    assign rd_value = ram_rdata[KEY_W-1:TIME_W];

    always_comb
    begin
        if (key_count_reg == '0)
        begin
            key_last = '0;
        end
        else if (32'(key_count_reg) >= MAX_KEYS)
        begin
            key_last = KEY_IDX_W'(MAX_KEYS - 1);
        end
        else
        begin
            key_last = KEY_IDX_W'(key_count_reg - 1'b1);
        end
    end

    always_comb
    begin
        unique case (state_reg)
            S_NEXT_RD: ram_raddr = next_reg;
            S_PREV_RD: ram_raddr = prev_reg;
            default:   ram_raddr = idx_reg;
        endcase
    end

    // one multiplier digit: mc times the low digit of mp
    always_comb
    begin
        part = '0;
        for (int k = 0; k < MUL_DIGIT; k++)
        begin
            if (mp_reg[k])
            begin
                part = part + (mc_reg << k);
            end
        end
    end

    always_comb
    begin
        msb = '0;
        for (int k = 0; k < FRAC_W; k++)
        begin
            if (pow_x_reg[k])
            begin
                msb = 4'(k);
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        ret_next       = ret_reg;
        query_next     = query_reg;
        idx_next       = idx_reg;
        next_next      = next_reg;
        prev_next      = prev_reg;
        tn_next        = tn_reg;
        tp_next        = tp_reg;
        vn_next        = vn_reg;
        vp_next        = vp_reg;
        den_next       = den_reg;
        rem_next       = rem_reg;
        t_next         = t_reg;
        cnt_next       = cnt_reg;
        pow_x_next     = pow_x_reg;
        pow_b_next     = pow_b_reg;
        log_int_next   = log_int_reg;
        frac_next      = frac_reg;
        ipart_next     = ipart_reg;
        r_next         = r_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        neg_next       = neg_reg;
        w_next         = w_reg;
        mc_next        = mc_reg;
        mp_next        = mp_reg;
        acc_next       = acc_reg;
        out_valid_next = out_valid_reg && out_stall;
        value_next     = value_reg;
        prev_out_next  = prev_out_reg;
        next_out_next  = next_out_reg;
        weight_next    = weight_reg;

        mul_go   = 1'b0;
        mul_mc   = '0;
        mul_mp   = '0;
        mul_ret  = S_IDLE;
        pow_fin  = 1'b0;
        pow_res  = '0;

        den_s    = $signed({3'b0, tn_reg}) - $signed({3'b0, tp_reg});
        num_s    = $signed({3'b0, query_reg}) - $signed({3'b0, tp_reg});
        if (next_reg == '0)
        begin
            den_s = den_s + DAY18;
            if (num_s < 0)
            begin
                num_s = num_s + DAY18;
            end
        end
        rem2     = {rem_reg[16:0], 1'b0};
        sh5      = 5'd16 - {1'b0, msb};
        z0       = 17'({1'b0, pow_x_reg[FRAC_W-1:0]}) << sh5;
        sq       = acc_reg[33:16];
        zn       = sq[17] ? sq[17:1] : sq[16:0];
        frac_sh  = {frac_reg[FRAC_W-2:0], sq[17]};
        neg_log  = {log_int_reg, 16'b0} - {5'b0, frac_sh};
        sh9      = 9'd14 + {1'b0, ipart_reg};
        diff18   = {1'b0, b_reg} - {1'b0, a_reg};
        dsh      = acc_reg[32:16];
        e19      = neg_reg ? $signed({2'b0, a_reg}) - $signed({2'b0, dsh})
                           : $signed({2'b0, a_reg}) + $signed({2'b0, dsh});
        dv       = {vn_reg[VALUE_W-1], vn_reg} - {vp_reg[VALUE_W-1], vp_reg};
        dv_mag   = dv[32] ? 33'(-dv) : dv;
        vsh      = acc_reg[48:16];
        vp34     = {{2{vp_reg[VALUE_W-1]}}, vp_reg};
        v34      = neg_reg ? vp34 - {1'b0, vsh} : vp34 + {1'b0, vsh};

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept && (operation == OP_EVAL))
                begin
                    query_next = query_time;
                    idx_next   = '0;
                    state_next = S_SCAN_RD;
                end
            end
            S_SCAN_RD:
            begin
                state_next = S_SCAN_CK;
            end
            S_SCAN_CK:
            begin
                if (query_reg <= rd_time)
                begin
                    next_next  = idx_reg;
                    state_next = S_NEXT_RD;
                end
                else if (idx_reg == key_last)
                begin
                    next_next  = '0;
                    state_next = S_NEXT_RD;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_SCAN_RD;
                end
            end
            S_NEXT_RD:
            begin
                state_next = S_NEXT_LD;
            end
            S_NEXT_LD:
            begin
                tn_next    = rd_time;
                vn_next    = rd_value;
                prev_next  = (next_reg == '0) ? key_last : next_reg - 1'b1;
                state_next = S_PREV_RD;
            end
            S_PREV_RD:
            begin
                state_next = S_PREV_LD;
            end
            S_PREV_LD:
            begin
                tp_next    = rd_time;
                vp_next    = rd_value;
                state_next = S_SPAN;
            end
            S_SPAN:
            begin
                if (den_s <= 0 || num_s < 0)
                begin
                    t_next     = '0;
                    pow_x_next = '0;
                    pow_b_next = 1'b0;
                    state_next = S_POW_INIT;
                end
                else if (num_s >= den_s)
                begin
                    t_next     = WEIGHT_ONE;
                    pow_x_next = WEIGHT_ONE;
                    pow_b_next = 1'b0;
                    state_next = S_POW_INIT;
                end
                else
                begin
                    den_next   = den_s[16:0];
                    rem_next   = num_s;
                    t_next     = '0;
                    cnt_next   = '0;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (rem2 >= {1'b0, den_reg})
                begin
                    rem_next = rem2 - {1'b0, den_reg};
                    t_next   = {1'b0, t_reg[14:0], 1'b1};
                end
                else
                begin
                    rem_next = rem2;
                    t_next   = {1'b0, t_reg[14:0], 1'b0};
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 4'd15)
                begin
                    pow_x_next = t_next;
                    pow_b_next = 1'b0;
                    state_next = S_POW_INIT;
                end
            end
            S_POW_INIT:
            begin
                if (ease_power_reg == '0 || pow_x_reg[FRAC_W])
                begin
                    pow_fin = 1'b1;
                    pow_res = WEIGHT_ONE;
                end
                else if (pow_x_reg == '0)
                begin
                    pow_fin = 1'b1;
                    pow_res = '0;
                end
                else
                begin
                    log_int_next = sh5;
                    frac_next    = '0;
                    cnt_next     = '0;
                    mul_go       = 1'b1;
                    mul_mc       = ACC_W'(z0);
                    mul_mp       = MP_W'(z0);
                    mul_ret      = S_LOG_STEP;
                end
            end
            S_LOG_STEP:
            begin
                // one squaring gives one fraction bit of log2
                frac_next = frac_sh;
                cnt_next  = cnt_reg + 1'b1;
                mul_go    = 1'b1;
                if (cnt_reg == 4'd15)
                begin
                    mul_mc  = ACC_W'(neg_log);
                    mul_mp  = MP_W'(ease_power_reg);
                    mul_ret = S_LOG_Q;
                end
                else
                begin
                    mul_mc  = ACC_W'(zn);
                    mul_mp  = MP_W'(zn);
                    mul_ret = S_LOG_STEP;
                end
            end
            S_LOG_Q:
            begin
                ipart_next = acc_reg[35:28];
                frac_next  = acc_reg[27:12];
                r_next     = 31'h4000_0000;
                cnt_next   = '0;
                state_next = S_EXP;
            end
            S_EXP:
            begin
                if (frac_reg[FRAC_W-1])
                begin
                    mul_go  = 1'b1;
                    mul_mc  = ACC_W'(r_reg);
                    mul_mp  = MP_W'(EXP_C[cnt_reg]);
                    mul_ret = S_EXP_STEP;
                end
                else
                begin
                    frac_next = frac_reg << 1;
                    cnt_next  = cnt_reg + 1'b1;
                    if (cnt_reg == 4'd15)
                    begin
                        state_next = S_POW_SH;
                    end
                end
            end
            S_EXP_STEP:
            begin
                r_next    = acc_reg[60:30];
                frac_next = frac_reg << 1;
                cnt_next  = cnt_reg + 1'b1;
                state_next = (cnt_reg == 4'd15) ? S_POW_SH : S_EXP;
            end
            S_POW_SH:
            begin
                pow_fin = 1'b1;
                if (sh9 >= 9'd31)
                begin
                    pow_res = '0;
                end
                else
                begin
                    pow_res = WEIGHT_W'(r_reg >> sh9[4:0]);
                end
            end
            S_EASE_MUL:
            begin
                neg_next = diff18[17];
                mul_go   = 1'b1;
                mul_mc   = ACC_W'(diff18[17] ? 17'(-diff18) : diff18[16:0]);
                mul_mp   = MP_W'(t_reg);
                mul_ret  = S_EASE_FIN;
            end
            S_EASE_FIN:
            begin
                if (e19 < 0)
                begin
                    w_next = '0;
                end
                else if (e19 > $signed({2'b0, WEIGHT_ONE}))
                begin
                    w_next = WEIGHT_ONE;
                end
                else
                begin
                    w_next = e19[16:0];
                end
                neg_next = dv[32];
                mul_go   = 1'b1;
                mul_mc   = ACC_W'(dv_mag);
                mul_mp   = MP_W'(w_next);
                mul_ret  = S_VAL_FIN;
            end
            S_VAL_FIN:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    value_next     = v34[VALUE_W-1:0];
                    prev_out_next  = prev_reg;
                    next_out_next  = next_reg;
                    weight_next    = w_reg;
                    state_next     = S_IDLE;
                end
            end
            S_MUL:
            begin
                acc_next = acc_reg + part;
                mc_next  = mc_reg << MUL_DIGIT;
                mp_next  = mp_reg >> MUL_DIGIT;
                if (mp_next == '0)
                begin
                    state_next = ret_reg;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (pow_fin)
        begin
            if (!pow_b_reg)
            begin
                a_next     = pow_res;
                pow_x_next = WEIGHT_ONE - t_reg;
                pow_b_next = 1'b1;
                state_next = S_POW_INIT;
            end
            else
            begin
                b_next     = WEIGHT_ONE - pow_res;
                state_next = S_EASE_MUL;
            end
        end

        if (mul_go)
        begin
            acc_next   = '0;
            mc_next    = mul_mc;
            mp_next    = mul_mp;
            ret_next   = mul_ret;
            state_next = S_MUL;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            ret_reg        <= S_IDLE;
            key_count_reg  <= COUNT_W'(1);
            ease_power_reg <= POWER_W'(8192);
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_KEY_COUNT:  key_count_reg  <= cfg_data[COUNT_W-1:0];
                    CFG_EASE_POWER: ease_power_reg <= cfg_data[POWER_W-1:0];
                    default:        key_count_reg  <= key_count_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        query_reg    <= query_next;
        idx_reg      <= idx_next;
        next_reg     <= next_next;
        prev_reg     <= prev_next;
        tn_reg       <= tn_next;
        tp_reg       <= tp_next;
        vn_reg       <= vn_next;
        vp_reg       <= vp_next;
        den_reg      <= den_next;
        rem_reg      <= rem_next;
        t_reg        <= t_next;
        cnt_reg      <= cnt_next;
        pow_x_reg    <= pow_x_next;
        pow_b_reg    <= pow_b_next;
        log_int_reg  <= log_int_next;
        frac_reg     <= frac_next;
        ipart_reg    <= ipart_next;
        r_reg        <= r_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        neg_reg      <= neg_next;
        w_reg        <= w_next;
        mc_reg       <= mc_next;
        mp_reg       <= mp_next;
        acc_reg      <= acc_next;
        value_reg    <= value_next;
        prev_out_reg <= prev_out_next;
        next_out_reg <= next_out_next;
        weight_reg   <= weight_next;
    end

endmodule
`default_nettype wire

// ===== src/kei_checker.sv =====
// Port-level checks for the keyframe eased interpolator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module kei_checker
    import kei_pkg::*;
(
    input wire logic                      clk,
    input wire logic                      rst_n,
    input wire logic                      in_valid,
    input wire logic                      in_stall,
    input wire logic                      operation,
    input wire logic                      out_valid,
    input wire logic                      out_stall,
    input wire logic signed [VALUE_W-1:0] value,
    input wire logic [WEIGHT_W-1:0]       weight
);

    // a held result beat keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(value) && $stable(weight))
        else $error("result beat changed while stalled");

    // eased weight never exceeds one
    a_weight_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> weight <= WEIGHT_ONE)
        else $error("weight above 1.0");

    // an evaluate beat makes the block busy
    a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && operation == OP_EVAL |=> in_stall)
        else $error("evaluate beat did not start work");

    // a write beat completes in its own cycle
    a_write_quick: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && operation == OP_WRITE |=> !in_stall)
        else $error("write beat stalled the input");

    // results only appear at the end of busy work
    a_out_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared without an evaluate in work");

endmodule

bind keyframe_eased_interpolator kei_checker u_kei_checker (.*);
`default_nettype wire
